// ===== hw/rtl/mm64_pkg.sv =====
package mm64_pkg;

	// Sequencer commands to the datapath, one active per cycle at most
	typedef struct packed {
		logic load;    // take a new operand set
		logic reduce;  // one restoring step of multiplicand mod modulus
		logic mult;    // one add-and-double step on the next multiplier bit
	} mm64_ctrl_t;

endpackage

// ===== hw/rtl/mm64_core.sv =====
module mm64_core #(
	parameter int WORD_BITS = 64
) (
	input  logic                   clk,
	input  mm64_pkg::mm64_ctrl_t   ctrl,
	input  logic [WORD_BITS-1:0]   multiplicand_w,
	input  logic [WORD_BITS-1:0]   multiplier_w,
	input  logic [WORD_BITS-1:0]   modulus_w,
	output logic [WORD_BITS-1:0]   acc
);

	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] r_q;    // remainder while reducing, then running multiplicand
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] sa_q;   // multiplicand bits, MSB first
	logic [WORD_BITS-1:0] sb_q;   // multiplier bits, LSB first

	logic                 dbl_cin;
	logic [WORD_BITS+1:0] dbl_sum;
	logic [WORD_BITS+1:0] dbl_diff;
	logic [WORD_BITS-1:0] dbl_res;
	logic [WORD_BITS+1:0] add_sum;
	logic [WORD_BITS+1:0] add_diff;
	logic [WORD_BITS-1:0] add_res;

	// Doubling unit: 2*r + cin, one conditional subtract (r < m so sum < 2m).
	// Shared between the reduction and the multiply phase.
	assign dbl_cin  = ctrl.reduce & sa_q[WORD_BITS-1];
	assign dbl_sum  = {1'b0, r_q, dbl_cin};
	assign dbl_diff = dbl_sum - {2'b00, m_q};
	assign dbl_res  = dbl_diff[WORD_BITS+1] ? dbl_sum[WORD_BITS-1:0]
	                                        : dbl_diff[WORD_BITS-1:0];

	// Accumulate unit: acc + r mod m
	assign add_sum  = {2'b00, acc_q} + {2'b00, r_q};
	assign add_diff = add_sum - {2'b00, m_q};
	assign add_res  = add_diff[WORD_BITS+1] ? add_sum[WORD_BITS-1:0]
	                                        : add_diff[WORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			m_q   <= modulus_w;
			r_q   <= '0;
			acc_q <= '0;
			sa_q  <= multiplicand_w;
			sb_q  <= multiplier_w;
		end else if (ctrl.reduce) begin
			r_q  <= dbl_res;
			sa_q <= {sa_q[WORD_BITS-2:0], 1'b0};
		end else if (ctrl.mult) begin
			if (sb_q[0]) begin
				acc_q <= add_res;
			end
			r_q  <= dbl_res;
			sb_q <= {1'b0, sb_q[WORD_BITS-1:1]};
		end
	end

	assign acc = acc_q;

endmodule

// ===== hw/rtl/modular_multiplier_64.sv =====
// Exact (multiplicand * multiplier) mod modulus on WORD_BITS-bit unsigned
// operands; input bits above WORD_BITS are ignored. One item at a time:
// after a transfer in, restoring reduction of the multiplicand, one step per
// multiplicand bit, then add-and-double over the multiplier bits, one step
// per bit (both on one shared doubling adder), then the output register is
// loaded once it is free or its result leaves. A zero modulus skips the
// arithmetic and returns 0 with zero_modulus set. in_stall is high while an
// item is in progress.
module modular_multiplier_64 #(
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] multiplicand,
	input  logic [63:0] multiplier,
	input  logic [63:0] modulus,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] product_mod,
	output logic        zero_modulus
);

	localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_REDUCE = 2'd1;
	localparam logic [1:0] S_MULT   = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 zm_q;
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] prod_q;
	logic                 zm_out_q;

	logic                 in_xfer;
	logic                 cnt_last;
	logic                 out_load;
	logic [WORD_BITS-1:0] multiplicand_w;
	logic [WORD_BITS-1:0] multiplier_w;
	logic [WORD_BITS-1:0] modulus_w;
	logic [WORD_BITS-1:0] acc;
	mm64_pkg::mm64_ctrl_t ctrl;

	assign multiplicand_w = multiplicand[WORD_BITS-1:0];
	assign multiplier_w   = multiplier[WORD_BITS-1:0];
	assign modulus_w      = modulus[WORD_BITS-1:0];

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign cnt_last = (cnt_q == CNT_W'(WORD_BITS - 1));
	// output register is free, or its result leaves on this edge
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		ctrl.load   = in_xfer;
		ctrl.reduce = (state_q == S_REDUCE);
		ctrl.mult   = (state_q == S_MULT);
	end

	mm64_core #(
		.WORD_BITS(WORD_BITS)
	) u_core (
		.clk           (clk),
		.ctrl          (ctrl),
		.multiplicand_w(multiplicand_w),
		.multiplier_w  (multiplier_w),
		.modulus_w     (modulus_w),
		.acc           (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			zm_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cnt_q <= '0;
						zm_q  <= (modulus_w == '0);
						state_q <= (modulus_w == '0) ? S_DONE : S_REDUCE;
					end
				end
				S_REDUCE: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= S_MULT;
					end
				end
				S_MULT: begin
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// acc stays zero on the zero-modulus path, as load clears it
	always_ff @(posedge clk) begin
		if (out_load) begin
			prod_q   <= acc;
			zm_out_q <= zm_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign product_mod  = 64'(prod_q);
	assign zero_modulus = zm_out_q;

endmodule
